/* rtl/qpnr_pkg.sv */
// Shared widths and types for the QUIC packet number reconstructor.
`default_nettype none

package qpnr_pkg;

	// Input item fields
	localparam int TRUNC_PN_W = 32;
	localparam int PN_LEN_W   = 3;
	localparam int S_TDATA_W  = 40;

	// Result item fields
	localparam int FULL_PN_W  = 62;
	localparam int M_TDATA_W  = 64;

	// Packet number field length codes, in bytes
	localparam logic [PN_LEN_W-1:0] PN_LEN_0 = 3'd0;
	localparam logic [PN_LEN_W-1:0] PN_LEN_1 = 3'd1;
	localparam logic [PN_LEN_W-1:0] PN_LEN_2 = 3'd2;
	localparam logic [PN_LEN_W-1:0] PN_LEN_3 = 3'd3;
	localparam logic [PN_LEN_W-1:0] PN_LEN_4 = 3'd4;

	// Window masks for field lengths of one to four bytes
	localparam logic [TRUNC_PN_W-1:0] WIN_MASK_1 = 32'h0000_00FF;
	localparam logic [TRUNC_PN_W-1:0] WIN_MASK_2 = 32'h0000_FFFF;
	localparam logic [TRUNC_PN_W-1:0] WIN_MASK_3 = 32'h00FF_FFFF;
	localparam logic [TRUNC_PN_W-1:0] WIN_MASK_4 = 32'hFFFF_FFFF;

	// One received header as held in the input register
	typedef struct packed {
		logic [PN_LEN_W-1:0]   pn_length;
		logic [TRUNC_PN_W-1:0] pn_field;
	} pn_item_t;

endpackage

`default_nettype wire

/* rtl/quic_packet_number_reconstructor_core.sv */
// Top level of the QUIC receive-side packet number reconstructor.
`default_nettype none

// Rebuilds full packet numbers from truncated header fields for one packet
// number space, picking the candidate nearest to largest+1 within a window of
// 2^(8*length) as in RFC 9000 appendix A.3, with guards at both ends of the
// 2^PN_SPACE_BITS space. Field lengths of 0 are taken as 1 byte and lengths
// above 4 as 4 bytes. Every input transaction yields one output transaction:
// full_pn in m_tdata and the accepted flag in m_tuser. A packet is accepted
// when its number is above the largest accepted so far, or when it is zero
// and the largest is still zero; an accepted number becomes the new largest.
// The block takes one transaction per clock unless a stalled output holds the
// input back, and offers each result from the result register, which the
// input register feeds. A stalled output holds the input back only once both
// the input and the result register are full. The rate is set by the feedback
// loop through the largest accepted number, whose reconstruct and compare are
// combinational and whose update is registered together with the result.
module quic_packet_number_reconstructor_core
	import qpnr_pkg::*;
#(
	parameter int PN_SPACE_BITS = 62
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // [31:0] received pn field, [34:32] pn_length
	// Result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,  // [61:0] full_pn
	output logic                      m_tuser   // [0] accepted
);

	localparam int W = PN_SPACE_BITS + 2;

	pn_item_t                 item_s1;
	logic                     valid_s1;
	logic                     valid_s2;
	logic [FULL_PN_W-1:0]     full_pn_s2;
	logic                     accepted_s2;
	logic [PN_SPACE_BITS-1:0] largest_q;

	logic                     load_s2;
	logic                     load_s1;

	logic [TRUNC_PN_W-1:0]    win_mask;
	logic [W-1:0]             win;
	logic [W-1:0]             hwin;
	logic [W-1:0]             mask_w;
	logic [W-1:0]             expected;
	logic [W-1:0]             cand;
	logic [W-1:0]             space_size;
	logic                     move_up;
	logic                     move_down;
	logic [W-1:0]             recon;
	logic [PN_SPACE_BITS-1:0] pn;
	logic                     ok;

	// Handshake: output register frees when empty or taken
	assign load_s2  = !valid_s2 || m_tready;
	assign load_s1  = s_tvalid && s_tready;
	assign s_tready = !valid_s1 || load_s2;

	// Window from the field length, out-of-range lengths clamped
	always_comb begin
		case (item_s1.pn_length) inside
			PN_LEN_0, PN_LEN_1: win_mask = WIN_MASK_1;
			PN_LEN_2:           win_mask = WIN_MASK_2;
			PN_LEN_3:           win_mask = WIN_MASK_3;
			default:            win_mask = WIN_MASK_4;
		endcase
	end

	// Candidate nearest to largest+1, moved by one window where needed
	always_comb begin
		mask_w     = {{(W-TRUNC_PN_W){1'b0}}, win_mask};
		win        = mask_w + W'(1);
		hwin       = win >> 1;
		expected   = {2'b00, largest_q} + W'(1);
		cand       = (expected & ~mask_w) |
		             {{(W-TRUNC_PN_W){1'b0}}, item_s1.pn_field & win_mask};
		space_size = W'(1) << PN_SPACE_BITS;
		move_up    = (expected >= hwin) && (cand <= expected - hwin) &&
		             (cand < space_size - win);
		move_down  = (cand > expected + hwin) && (cand >= win);
		if (move_up) begin
			recon = cand + win;
		end else if (move_down) begin
			recon = cand - win;
		end else begin
			recon = cand;
		end
		pn = recon[PN_SPACE_BITS-1:0];
		ok = (largest_q < pn) || ((pn == '0) && (largest_q == '0));
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.pn_field  <= s_tdata[TRUNC_PN_W-1:0];
			item_s1.pn_length <= s_tdata[TRUNC_PN_W+PN_LEN_W-1:TRUNC_PN_W];
		end
	end

	// Result register and largest accepted number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			largest_q <= '0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1 && ok) begin
				largest_q <= pn;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			full_pn_s2  <= FULL_PN_W'(pn);
			accepted_s2 <= ok;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_TDATA_W-FULL_PN_W){1'b0}}, full_pn_s2};
	assign m_tuser  = accepted_s2;

endmodule

`default_nettype wire

/* rtl/qpnr_checker.sv */
// Port-level checks for the packet number reconstructor, bound to the top level.
`default_nettype none

module qpnr_checker
	import qpnr_pkg::*;
#(
	parameter int PN_SPACE_BITS = 62
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic [S_TDATA_W-1:0] s_tdata,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic                 m_tuser
);

	logic                     m_xfer;
	logic [M_TDATA_W-1:0]     last_pn_q;

	assign m_xfer = m_tvalid && m_tready;

	// Largest number seen in accepted output transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pn_q <= '0;
		end else if (m_xfer && m_tuser) begin
			last_pn_q <= m_tdata;
		end
	end

	// A stalled input offer stays with the same header
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input offer changed while stalled");

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Packet numbers stay inside the number space, padding zero
	a_in_space: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >> PN_SPACE_BITS) == '0)
		else $error("packet number outside the number space");

	// Accepted numbers rise strictly, except the first zero repeat
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && m_tuser |->
			(m_tdata > last_pn_q) || ((m_tdata == '0) && (last_pn_q == '0)))
		else $error("accepted packet number not above the largest");

endmodule

bind quic_packet_number_reconstructor_core qpnr_checker #(
	.PN_SPACE_BITS(PN_SPACE_BITS)
) u_qpnr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* sim/quic_packet_number_reconstructor_core_tb.sv */
// Self-checking testbench for the QUIC packet number reconstructor core.
`timescale 1ns / 1ps

module quic_packet_number_reconstructor_core_tb;
	import qpnr_pkg::*;

	localparam logic [63:0]         PN_SPACE = 64'd1 << FULL_PN_W;
	localparam int                  N_RANDOM = 1530;
	localparam int                  IDLE_PCT = 14;
	localparam int                  HOLD_CYCLES = 64;

	typedef struct {
		logic [FULL_PN_W-1:0] full_pn;
		logic                 accepted;
	} pn_result_t;

	// Tracks the largest accepted number and the queue of expected decode results
	class pn_scoreboard;
		logic [FULL_PN_W-1:0] largest;
		pn_result_t           pending_q[$];
		int                   errors;
		int                   n_acc;
		int                   n_rej;

		function new();
			largest = '0;
			errors  = 0;
			n_acc   = 0;
			n_rej   = 0;
		endfunction

		// Decode one accepted header and queue its expected result
		function void note_input(logic [TRUNC_PN_W-1:0] trunc, logic [PN_LEN_W-1:0] len_code);
			int unsigned nbytes;
			logic [63:0] win, hwin, mask, nxt, cand, pn;
			pn_result_t  res;
			if (len_code < PN_LEN_1)
				nbytes = 1;
			else if (len_code > PN_LEN_4)
				nbytes = 4;
			else
				nbytes = {29'd0, len_code};
			win  = 64'd1 << (8 * nbytes);
			hwin = win >> 1;
			mask = win - 64'd1;
			nxt  = {2'b00, largest} + 64'd1;
			cand = (nxt & ~mask) | ({32'd0, trunc} & mask);
			// nearest candidate to largest+1, guarded at both ends of the space
			if (nxt >= hwin && cand <= nxt - hwin && cand < PN_SPACE - win)
				pn = cand + win;
			else if (cand > nxt + hwin && cand >= win)
				pn = cand - win;
			else
				pn = cand;
			res.full_pn  = pn[FULL_PN_W-1:0];
			res.accepted = (res.full_pn > largest) || (res.full_pn == '0 && largest == '0);
			if (res.accepted) begin
				largest = res.full_pn;
				n_acc++;
			end else begin
				n_rej++;
			end
			pending_q.push_back(res);
		endfunction

		// Compare one result transaction against the oldest expectation
		function void check_result(logic [FULL_PN_W-1:0] full_pn, logic accepted);
			pn_result_t exp_res;
			if (pending_q.size() == 0) begin
				$error("unexpected result: full_pn 0x%0h accepted %0b", full_pn, accepted);
				errors++;
				return;
			end
			exp_res = pending_q.pop_front();
			if (full_pn !== exp_res.full_pn) begin
				$error("full_pn mismatch: expected 0x%0h, actual 0x%0h",
					exp_res.full_pn, full_pn);
				errors++;
			end
			if (accepted !== exp_res.accepted) begin
				$error("accepted mismatch: expected %0b, actual %0b", exp_res.accepted, accepted);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	pn_scoreboard sb;
	bit           calm = 1'b0;     // no idling on either side while set
	bit           hold_req = 1'b0; // receiver holds off while set

	quic_packet_number_reconstructor_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

	// Offer one header and wait for its transaction
	task automatic send_item(input logic [TRUNC_PN_W-1:0] trunc, input logic [PN_LEN_W-1:0] len);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - TRUNC_PN_W - PN_LEN_W){1'b0}}, len, trunc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(trunc, len);
	endtask

	// Receiver ready: random stalls plus one long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= (!calm && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[FULL_PN_W-1:0], m_tuser);
	end

	// Stimulus
	initial begin
		int                    i, pick, d, wait_cyc;
		logic [63:0]           pn, base;
		logic [TRUNC_PN_W-1:0] trunc, mask;
		logic [PN_LEN_W-1:0]   len;

		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero repeat, length clamping, masking, window moves
		send_item(32'h0000_0000, PN_LEN_1);   // zero right after reset
		send_item(32'h0000_0000, PN_LEN_1);   // zero repeat, still accepted
		send_item(32'h0000_0001, PN_LEN_0);   // length 0 taken as 1
		send_item(32'h0000_0001, PN_LEN_1);   // duplicate
		send_item(32'hFFFF_FF02, PN_LEN_1);   // bits above the field ignored
		send_item(32'h0000_00FF, PN_LEN_1);   // not moved down below zero
		send_item(32'h0000_0010, PN_LEN_1);
		send_item(32'h0000_00F0, PN_LEN_1);   // moves down one window, old
		send_item(32'h0000_0005, PN_LEN_1);
		send_item(32'h0000_01F0, PN_LEN_2);
		send_item(32'h0000_0010, PN_LEN_1);   // moves up one window
		send_item(32'h0000_0300, 3'd5);       // lengths above 4 taken as 4
		send_item(32'h7FFF_FFFF, 3'd6);
		send_item(32'hFFFF_FFFF, 3'd7);
		send_item(32'h0000_0000, PN_LEN_4);   // crosses 2^32
		send_item(32'hFFFF_FFFF, PN_LEN_4);   // moves down, old
		send_item(32'h0000_00FF, PN_LEN_1);
		send_item(32'h0000_FFFF, PN_LEN_2);
		send_item(32'h00FF_FFFF, PN_LEN_3);
		send_item(32'h0000_0000, PN_LEN_2);
		send_item(32'hFFFF_FFFF, PN_LEN_4);

		// Random: mostly in-order streams with reordering, jumps and noise
		for (i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 600 && i < 800);
			if (i == 300)
				hold_req = 1'b1;
			pick = $urandom_range(99);
			if (pick < 12) begin
				trunc = $urandom;
				len   = PN_LEN_W'($urandom_range(0, 7));
			end else begin
				base = {2'b00, sb.largest};
				if (pick < 70) begin
					pn = base + 64'($urandom_range(1, 3));
				end else if (pick < 86) begin
					d  = $urandom_range(0, 40);
					pn = (base > 64'(d)) ? base - 64'(d) : 64'd0;
				end else if (pick < 94) begin
					pn = base + 64'($urandom_range(4, 5000));
				end else begin
					pn = base + 64'($urandom_range(1, 32'h3FFF_FFFF));
				end
				len = PN_LEN_W'($urandom_range(1, 4));
				case (len)
					PN_LEN_1: mask = WIN_MASK_1;
					PN_LEN_2: mask = WIN_MASK_2;
					PN_LEN_3: mask = WIN_MASK_3;
					default:  mask = WIN_MASK_4;
				endcase
				trunc = pn[TRUNC_PN_W-1:0] & mask;
				// occasional junk above the field
				if ($urandom_range(9) == 0)
					trunc = trunc | ($urandom & ~mask);
			end
			send_item(trunc, len);
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// Drain, then allow for the pipeline latency
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		for (wait_cyc = 0; wait_cyc < 10; wait_cyc++)
			@(posedge clk);

		$display("Decoded %0d headers: %0d accepted, %0d old or duplicate, largest 0x%0h",
			sb.n_acc + sb.n_rej, sb.n_acc, sb.n_rej, sb.largest);
		$display("Covered length clamping, masking, window moves and a long output stall");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/qpnr_pkg.sv
rtl/quic_packet_number_reconstructor_core.sv
rtl/qpnr_checker.sv
sim/quic_packet_number_reconstructor_core_tb.sv
